FILE: sv/time_binned_event_counter_defines.svh
// Assertion macros used by the time-binned event counter core.
`ifndef TIME_BINNED_EVENT_COUNTER_DEFINES_SVH
`define TIME_BINNED_EVENT_COUNTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TBEC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbec: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TBEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbec: next-cycle check failed");

`endif

FILE: sv/tbec_pkg.sv
// Package: types, widths and codes of the time-binned event counter.
package tbec_pkg;

    localparam int NUM_BINS_DEF = 1024;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 10;
    localparam int OUT_BIN_W  = 11;
    localparam int COUNT_W    = 8;
    localparam int PERIOD_W   = 16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD = '0;
    localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RST = 16'd1;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_EVENT = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Source of read_count in the result stage.
    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_MEM  = 2'd1,
        SEL_CUR  = 2'd2
    } read_sel_t;

endpackage

FILE: sv/tbec_in_if.sv
// Request channel interface: valid/ready with op and read index.
interface tbec_in_if;
    import tbec_pkg::*;

    logic             valid;
    logic             ready;
    op_t              op;
    logic [IDX_W-1:0] read_index;

    modport source (output valid, output op, output read_index, input ready);
    modport sink   (input valid, input op, input read_index, output ready);
endinterface

FILE: sv/tbec_out_if.sv
// Result channel interface: valid/ready with bin status and read count.
interface tbec_out_if;
    import tbec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_BIN_W-1:0] bin_index;
    logic [OUT_BIN_W-1:0] filled_bins;
    logic                 finished;
    logic [COUNT_W-1:0]   read_count;

    modport source (output valid, output bin_index, output filled_bins,
                    output finished, output read_count, input ready);
    modport sink   (input valid, input bin_index, input filled_bins,
                    input finished, input read_count, output ready);
endinterface

FILE: sv/tbec_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/tbec_cfg.sv
// APB register block: holds the tick period.
module tbec_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tbec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tbec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [tbec_pkg::PERIOD_W-1:0]    tick_period
);
    import tbec_pkg::*;

    logic [PERIOD_W-1:0]  tick_period_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RST;
        end
        else if (wr_en && (reg_idx == REG_TICK_PERIOD))
        begin
            tick_period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TICK_PERIOD)
        begin
            prdata = APB_DATA_W'(tick_period_reg);
        end
    end

    assign tick_period = tick_period_reg;
endmodule

FILE: sv/tbec_core.sv
// Counter pipeline: request register, state update, middle stage, result register.
`include "time_binned_event_counter_defines.svh"

module tbec_core #(
    parameter int NUM_BINS = tbec_pkg::NUM_BINS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tbec_pkg::PERIOD_W-1:0] tick_period,
    tbec_in_if.sink                       item,
    tbec_out_if.source                    result
);
    import tbec_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS + 1);
    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int CMP_W  = (BIN_W > IDX_W) ? BIN_W : IDX_W;

    // Request register
    logic             valid_a_reg;
    op_t              op_a_reg;
    logic [IDX_W-1:0] ridx_a_reg;

    // Measurement state; the current bin's count lives in a register and is
    // written to the store when the bin closes, so every store entry below
    // the current bin has been written since the last start.
    logic [BIN_W-1:0]    cur_bin_reg, cur_bin_next;
    logic [PERIOD_W-1:0] countdown_reg, countdown_next;
    logic [BIN_W-1:0]    recorded_reg, recorded_next;
    logic                done_reg, done_next;
    logic [COUNT_W-1:0]  cur_count_reg, cur_count_next;

    // Middle stage, waits for the registered store read
    logic                 valid_b_reg;
    logic [OUT_BIN_W-1:0] bin_b_reg;
    logic [OUT_BIN_W-1:0] filled_b_reg;
    logic                 fin_b_reg;
    read_sel_t            sel_b_reg;
    logic [COUNT_W-1:0]   cnt_b_reg;

    // Result register
    logic                 valid_o_reg;
    logic [OUT_BIN_W-1:0] bin_o_reg;
    logic [OUT_BIN_W-1:0] filled_o_reg;
    logic                 fin_o_reg;
    logic [COUNT_W-1:0]   count_o_reg;
    logic [COUNT_W-1:0]   count_o_next;

    logic o_move, b_free, a_free, a_fire, b_fire;
    logic ram_we;
    logic [COUNT_W-1:0] ram_rdata;
    logic [PERIOD_W-1:0] cd_dec;
    logic last_bin;
    logic [CMP_W-1:0] ridx_ext, cur_ext;
    read_sel_t sel_next;

    assign o_move = !valid_o_reg || result.ready;
    assign b_fire = valid_b_reg && o_move;
    assign b_free = !valid_b_reg || o_move;
    assign a_fire = valid_a_reg && b_free;
    assign a_free = !valid_a_reg || b_free;

    assign item.ready = a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (a_free)
        begin
            valid_a_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && item.valid)
        begin
            op_a_reg   <= item.op;
            ridx_a_reg <= item.read_index;
        end
    end

    assign cd_dec   = countdown_reg - PERIOD_W'(1);
    assign last_bin = (cur_bin_reg == BIN_W'(NUM_BINS - 1));

    always_comb
    begin
        cur_bin_next   = cur_bin_reg;
        countdown_next = countdown_reg;
        recorded_next  = recorded_reg;
        done_next      = done_reg;
        cur_count_next = cur_count_reg;
        ram_we         = 1'b0;
        if (a_fire)
        begin
            unique case (op_a_reg)
                OP_START:
                begin
                    cur_bin_next   = '0;
                    countdown_next = tick_period;
                    recorded_next  = BIN_W'(1);
                    done_next      = 1'b0;
                    cur_count_next = '0;
                end
                OP_EVENT:
                begin
                    if (!done_reg)
                    begin
                        cur_count_next = cur_count_reg + COUNT_W'(1);
                    end
                end
                OP_TICK:
                begin
                    if (!done_reg)
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0)
                        begin
                            // close the bin: its count goes to the store
                            ram_we         = 1'b1;
                            cur_count_next = '0;
                            cur_bin_next   = cur_bin_reg + BIN_W'(1);
                            if (!last_bin)
                            begin
                                recorded_next  = recorded_reg + BIN_W'(1);
                                countdown_next = tick_period;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                end
            endcase
        end
    end

    // Where a read's count comes from; bins past the current one read zero.
    assign ridx_ext = CMP_W'(ridx_a_reg);
    assign cur_ext  = CMP_W'(cur_bin_reg);

    always_comb
    begin
        sel_next = SEL_ZERO;
        if (op_a_reg == OP_READ)
        begin
            priority if (ridx_ext < cur_ext)
            begin
                sel_next = SEL_MEM;
            end
            else if ((ridx_ext == cur_ext) && !done_reg)
            begin
                sel_next = SEL_CUR;
            end
        end
    end

    tbec_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_bin_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_bin_reg[ADDR_W-1:0]),
        .wdata (cur_count_reg),
        .re    (a_fire),
        .raddr (ADDR_W'(ridx_a_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bin_reg   <= '0;
            countdown_reg <= PERIOD_W'(1);
            recorded_reg  <= BIN_W'(1);
            done_reg      <= 1'b0;
            cur_count_reg <= '0;
            valid_b_reg   <= 1'b0;
            valid_o_reg   <= 1'b0;
        end
        else
        begin
            cur_bin_reg   <= cur_bin_next;
            countdown_reg <= countdown_next;
            recorded_reg  <= recorded_next;
            done_reg      <= done_next;
            cur_count_reg <= cur_count_next;
            if (b_free)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (o_move)
            begin
                valid_o_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            bin_b_reg    <= OUT_BIN_W'(cur_bin_next);
            filled_b_reg <= OUT_BIN_W'(recorded_next);
            fin_b_reg    <= done_next;
            sel_b_reg    <= sel_next;
            cnt_b_reg    <= cur_count_reg;
        end
    end

    always_comb
    begin
        unique case (sel_b_reg)
            SEL_MEM:  count_o_next = ram_rdata;
            SEL_CUR:  count_o_next = cnt_b_reg;
            default:  count_o_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            bin_o_reg    <= bin_b_reg;
            filled_o_reg <= filled_b_reg;
            fin_o_reg    <= fin_b_reg;
            count_o_reg  <= count_o_next;
        end
    end

    assign result.valid       = valid_o_reg;
    assign result.bin_index   = bin_o_reg;
    assign result.filled_bins = filled_o_reg;
    assign result.finished    = fin_o_reg;
    assign result.read_count  = count_o_reg;

    `TBEC_ASSERT_IMPL(a_done_at_end, done_reg, cur_bin_reg == BIN_W'(NUM_BINS))
    `TBEC_ASSERT_IMPL(a_bin_in_range, !done_reg, cur_bin_reg < BIN_W'(NUM_BINS))
    `TBEC_ASSERT_IMPL(a_recorded_track, !done_reg, recorded_reg == cur_bin_reg + BIN_W'(1))
    `TBEC_ASSERT_IMPL(a_write_on_tick, ram_we, a_fire && (op_a_reg == OP_TICK) && !done_reg)
    `TBEC_ASSERT_NEXT(a_mid_loaded, a_fire, valid_b_reg)
endmodule

FILE: sv/time_binned_event_counter.sv
// Requests pass the request register, the middle stage, then the result register.
// Throughput: one request per cycle unless result.ready holds the pipeline; the bin
// read-modify-write is avoided: the open bin counts in a register, stored when it closes.
// The store is a 1-port-write, 1-port-read RAM with registered read; it needs no clear:
// bins below the current one are written since the last start, the rest read as zero.
// Reset: asynchronous, active low; bin 0 open, countdown 1, one bin recorded, tick period 1.
module time_binned_event_counter #(
    parameter int NUM_BINS = tbec_pkg::NUM_BINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbec_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    tbec_in_if.sink                         item,
    tbec_out_if.source                      result
);
    import tbec_pkg::*;

    logic [PERIOD_W-1:0] tick_period;

    tbec_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .tick_period (tick_period)
    );

    tbec_core #(
        .NUM_BINS (NUM_BINS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_period (tick_period),
        .item        (item),
        .result      (result)
    );
endmodule
